[src/fsd_pkg.sv]
// Shared types and constants of the frame-level silence detector.
`default_nettype none

package fsd_pkg;

	localparam int SAMPLE_W       = 16;
	localparam int AVG_W          = 16;
	localparam int INDEX_W        = 32;
	localparam int FRAME_LENGTH_W = 24;
	localparam int THRESHOLD_W    = 15;
	localparam int CFG_INDEX_W    = 8;
	localparam int CFG_DATA_W     = 24;

	localparam logic [FRAME_LENGTH_W-1:0] FRAME_LENGTH_RESET = 24'd24000;
	localparam logic [THRESHOLD_W-1:0]    THRESHOLD_RESET    = 15'd1000;

	// Configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_LENGTH = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD    = 8'd1;

	typedef enum logic [1:0] {
		CLASS_SILENCE = 2'd0,
		CLASS_SIGNAL  = 2'd1,
		CLASS_UNKNOWN = 2'd2
	} class_t;

	typedef enum logic [1:0] {
		ST_IDLE   = 2'd0,
		ST_CHECK  = 2'd1,
		ST_DIVIDE = 2'd2,
		ST_REPORT = 2'd3
	} state_t;

endpackage

`default_nettype wire

[src/fsd_if.sv]
// Channel interfaces of the frame-level silence detector: samples, results, configuration.
`default_nettype none

interface fsd_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [fsd_pkg::SAMPLE_W-1:0] sample;
	logic                                end_of_stream;

	modport source (output valid, output sample, output end_of_stream, input ready);
	modport sink   (input valid, input sample, input end_of_stream, output ready);
endinterface

interface fsd_out_if;
	logic                         valid;
	logic                         ready;
	logic                         is_signal;
	logic [fsd_pkg::INDEX_W-1:0]  frame_start;
	logic [fsd_pkg::AVG_W-1:0]    average_level;

	modport source (output valid, output is_signal, output frame_start, output average_level,
		input ready);
	modport sink   (input valid, input is_signal, input frame_start, input average_level,
		output ready);
endinterface

interface fsd_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [fsd_pkg::CFG_INDEX_W-1:0] index;
	logic [fsd_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[src/fsd_divider.sv]
// Bit-serial restoring divider: frame magnitude sum over sample count, one quotient bit a cycle.
`default_nettype none

module fsd_divider #(
	parameter int FRAME_COUNT_BITS = 24
) (
	input  wire logic                                           clk,
	input  wire logic                                           arst_n,
	input  wire logic                                           start,
	input  wire logic [fsd_pkg::AVG_W+FRAME_COUNT_BITS-1:0]     dividend,
	input  wire logic [FRAME_COUNT_BITS-1:0]                    divisor,
	output logic                                                done,
	output logic [fsd_pkg::AVG_W-1:0]                           quotient
);

	localparam int QW    = fsd_pkg::AVG_W;
	localparam int SUM_W = QW + FRAME_COUNT_BITS;
	localparam int CNT_W = $clog2(QW);

	logic                        busy_q;
	logic                        done_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [FRAME_COUNT_BITS-1:0] rem_q;
	logic [FRAME_COUNT_BITS-1:0] div_q;
	logic [QW-1:0]               quo_q;

	logic [FRAME_COUNT_BITS:0]   trial;
	logic                        ge;
	logic [FRAME_COUNT_BITS:0]   diff;

	// Bring down the next dividend bit and try the subtract.
	always_comb begin
		trial = {rem_q, quo_q[QW-1]};
		diff  = trial - {1'b0, div_q};
		ge    = trial >= {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(QW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Quotient bits shift in where the low dividend bits shift out.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[SUM_W-1:QW];
			quo_q <= dividend[QW-1:0];
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[FRAME_COUNT_BITS-1:0] : trial[FRAME_COUNT_BITS-1:0];
			quo_q <= {quo_q[QW-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

[src/frame_level_silence_detector_top.sv]
// Top level of the frame-level silence detector.
// Usage:
//   samples : one signed 16-bit PCM sample per item plus an end_of_stream mark.
//   results : an item only when a frame's class (signal / silence) differs from
//             the previous frame's, and always for a stream's first frame; it
//             carries the frame's first sample index and its mean magnitude.
//   cfg     : register writes (index 0 frame_length, index 1 threshold_level),
//             always ready; write only while the block is idle.
// Steps: an item that does not close a frame passes through accept and close
//   check. An item that closes a frame passes through accept, start, a
//   bit-serial divider that produces one quotient bit per cycle, finish and
//   report, and its result is then held in the output register. A new
//   sample is taken only once the block is back in its idle step.
// Stall: the result sits in an output register; the next sample is accepted
//   meanwhile, and the block only holds in its report step when a new result
//   is due while the old one is still not taken.
// Reset: clears the frame sum, count, sample index and last class (unknown);
//   the registers return to 24000 samples and a threshold of 1000. End of
//   stream clears the stream state the same way once the closing frame
//   reports, so the next sample starts a new stream.
`default_nettype none

module frame_level_silence_detector_top #(
	parameter int FRAME_COUNT_BITS = 24
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	fsd_in_if.sink     samples,
	fsd_out_if.source  results,
	fsd_cfg_if.sink    cfg
);

	localparam int SUM_W = fsd_pkg::AVG_W + FRAME_COUNT_BITS;
	localparam int CMP_W = (FRAME_COUNT_BITS > fsd_pkg::FRAME_LENGTH_W) ?
		FRAME_COUNT_BITS : fsd_pkg::FRAME_LENGTH_W;

	fsd_pkg::state_t state_q, state_d;

	// Configuration registers
	logic [fsd_pkg::FRAME_LENGTH_W-1:0] frame_length_q;
	logic [fsd_pkg::THRESHOLD_W-1:0]    threshold_q;

	// Stream state
	logic [SUM_W-1:0]             sum_q;
	logic [FRAME_COUNT_BITS-1:0]  count_q;
	logic [fsd_pkg::INDEX_W-1:0]  index_q;
	logic [fsd_pkg::INDEX_W-1:0]  start_q;
	logic                         eos_q;
	fsd_pkg::class_t              last_class_q;

	// Output register
	logic                         out_valid_q;
	logic                         is_signal_q;
	logic [fsd_pkg::INDEX_W-1:0]  frame_start_q;
	logic [fsd_pkg::AVG_W-1:0]    average_q;

	logic                         in_fire;
	logic [fsd_pkg::AVG_W:0]      mag;
	logic                         close_frame;
	logic                         div_start;
	logic                         div_done;
	logic [fsd_pkg::AVG_W-1:0]    avg;
	logic [FRAME_COUNT_BITS-1:0]  divisor;
	fsd_pkg::class_t              cls;
	logic                         emit;
	logic                         report_go;

	assign samples.ready = (state_q == fsd_pkg::ST_IDLE);
	assign in_fire       = samples.valid && samples.ready;
	assign cfg.ready     = 1'b1;

	// Magnitude of the sample; the most negative value gives 32768.
	assign mag = samples.sample[fsd_pkg::SAMPLE_W-1] ?
		(17'h10000 - {1'b0, samples.sample}) : {1'b0, samples.sample};

	// Close on end of stream, on a full frame, or when the counter tops out.
	assign close_frame = eos_q ||
		(CMP_W'(count_q) >= CMP_W'(frame_length_q)) ||
		(count_q == {FRAME_COUNT_BITS{1'b1}});

	assign div_start = (state_q == fsd_pkg::ST_CHECK) && close_frame;
	assign divisor   = (count_q == '0) ? FRAME_COUNT_BITS'(1) : count_q;

	fsd_divider #(
		.FRAME_COUNT_BITS(FRAME_COUNT_BITS)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (avg)
	);

	// Classify the finished frame and decide whether it reports.
	assign cls       = (avg > {1'b0, threshold_q}) ? fsd_pkg::CLASS_SIGNAL :
		fsd_pkg::CLASS_SILENCE;
	assign emit      = (cls != last_class_q);
	assign report_go = (state_q == fsd_pkg::ST_REPORT) &&
		(!emit || !out_valid_q || results.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fsd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			fsd_pkg::ST_IDLE: begin
				if (in_fire) state_d = fsd_pkg::ST_CHECK;
			end
			fsd_pkg::ST_CHECK: begin
				state_d = close_frame ? fsd_pkg::ST_DIVIDE : fsd_pkg::ST_IDLE;
			end
			fsd_pkg::ST_DIVIDE: begin
				if (div_done) state_d = fsd_pkg::ST_REPORT;
			end
			fsd_pkg::ST_REPORT: begin
				if (report_go) state_d = fsd_pkg::ST_IDLE;
			end
			default: begin
				state_d = fsd_pkg::ST_IDLE;
			end
		endcase
	end

	// Configuration writes; unknown indexes drop.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_length_q <= fsd_pkg::FRAME_LENGTH_RESET;
			threshold_q    <= fsd_pkg::THRESHOLD_RESET;
		end else if (cfg.valid && cfg.ready) begin
			if (cfg.index == fsd_pkg::REG_FRAME_LENGTH)
				frame_length_q <= cfg.data[fsd_pkg::FRAME_LENGTH_W-1:0];
			else if (cfg.index == fsd_pkg::REG_THRESHOLD)
				threshold_q <= cfg.data[fsd_pkg::THRESHOLD_W-1:0];
		end
	end

	// Stream state: accumulate on accept, restart the frame on report.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q        <= '0;
			count_q      <= '0;
			index_q      <= '0;
			start_q      <= '0;
			eos_q        <= 1'b0;
			last_class_q <= fsd_pkg::CLASS_UNKNOWN;
		end else if (in_fire) begin
			sum_q   <= sum_q + SUM_W'(mag);
			count_q <= count_q + 1'b1;
			index_q <= index_q + 1'b1;
			eos_q   <= samples.end_of_stream;
		end else if (report_go) begin
			sum_q   <= '0;
			count_q <= '0;
			if (eos_q) begin
				index_q      <= '0;
				start_q      <= '0;
				last_class_q <= fsd_pkg::CLASS_UNKNOWN;
			end else begin
				start_q      <= index_q;
				last_class_q <= cls;
			end
		end
	end

	// Output valid: drop when taken, raise on a class change.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (report_go && emit) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (report_go && emit) begin
			is_signal_q   <= (cls == fsd_pkg::CLASS_SIGNAL);
			frame_start_q <= start_q;
			average_q     <= avg;
		end
	end

	assign results.valid         = out_valid_q;
	assign results.is_signal     = is_signal_q;
	assign results.frame_start   = frame_start_q;
	assign results.average_level = average_q;

endmodule

`default_nettype wire

[src/fsd_checker.sv]
// Port-level assertions of the frame-level silence detector and their binding.
`default_nettype none

module fsd_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         in_valid,
	input wire logic                         in_ready,
	input wire logic                         out_valid,
	input wire logic                         out_ready,
	input wire logic                         is_signal,
	input wire logic [fsd_pkg::INDEX_W-1:0]  frame_start,
	input wire logic [fsd_pkg::AVG_W-1:0]    average_level
);

	// A waiting result holds until taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(is_signal) &&
		$stable(frame_start) && $stable(average_level))
		else $error("result changed or dropped while stalled");

	// Each sample takes at least the accept and the close check.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("sample accepted in back-to-back cycles");

	// A new result is only written from the report step, never while idle.
	a_result_from_report: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared while the input side was idle");

	// The mean magnitude never exceeds the largest sample magnitude.
	a_avg_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> average_level <= 16'd32768)
		else $error("average level out of range");

endmodule

bind frame_level_silence_detector_top fsd_checker u_fsd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (samples.valid),
	.in_ready      (samples.ready),
	.out_valid     (results.valid),
	.out_ready     (results.ready),
	.is_signal     (results.is_signal),
	.frame_start   (results.frame_start),
	.average_level (results.average_level)
);

`default_nettype wire
